// ===== src/sha256_stream_hasher_assert.svh =====
`ifndef SHA256_STREAM_HASHER_ASSERT_SVH
`define SHA256_STREAM_HASHER_ASSERT_SVH
// implication checked every clock outside reset
`define SHA_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define SHA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

// ===== src/sha_pkg.sv =====
package sha_pkg;
  localparam int BlockBytes = 64;
  localparam int LenPos = 56;
  localparam logic [7:0] PadByte = 8'h80;
  localparam logic [0:0] FuncAbsorb = 1'b0;
  localparam logic [0:0] FuncFinish = 1'b1;

  typedef logic [31:0] word_t;

  localparam word_t InitH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  localparam word_t RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

  function automatic word_t rotr(input word_t x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  typedef struct packed {
    word_t a, b, c, d, e, f, g, h;
  } vars_t;
endpackage

// ===== src/sha_round.sv =====
module sha_round (
  input  sha_pkg::vars_t v,
  input  sha_pkg::word_t k,
  input  sha_pkg::word_t w,
  output sha_pkg::vars_t v_next
);
  import sha_pkg::*;
  word_t t1, t2;
  always_comb begin
    t1 = v.h + (rotr(v.e, 6) ^ rotr(v.e, 11) ^ rotr(v.e, 25)) +
         ((v.e & v.f) ^ (~v.e & v.g)) + k + w;
    t2 = (rotr(v.a, 2) ^ rotr(v.a, 13) ^ rotr(v.a, 22)) +
         ((v.a & v.b) ^ (v.a & v.c) ^ (v.b & v.c));
    v_next = '{a: t1 + t2, b: v.a, c: v.b, d: v.c, e: v.d + t1, f: v.e, g: v.f, h: v.g};
  end
endmodule

// ===== src/sha256_stream_hasher.sv =====
// Absorb: one byte per cycle into a 64-byte buffer; the 64th byte starts a
// compression (schedule load, 64 rounds, fold), during which input is stalled.
// Finish: zero fill to the end of the block (and a further block when the
// length spills into an extra block), one or two compressions, then
// eight digest words at one per cycle as m_tready allows. Buffer memory has a
// registered read; schedule words live in a 16-entry circular window.
// Synchronous active-high reset restores the initial hash and zero counts.
module sha256_stream_hasher (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,  // [7:0] data_byte
  input  logic        s_tuser,  // [0] func
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,  // [31:0] digest_word, [34:32] word_index
  output logic        m_tlast   // last_word
);
  import sha_pkg::*;
  `include "sha256_stream_hasher_assert.svh"

  localparam logic [2:0] StIdle = 3'd0, StPad = 3'd1, StLoad = 3'd2,
    StRound = 3'd3, StFold = 3'd4, StOut = 3'd5;

  logic [2:0]  state;
  logic [7:0]  buf_mem [64];
  logic [7:0]  rd_byte;
  logic [5:0]  rd_addr;
  logic [5:0]  fill;
  logic [63:0] byte_count;
  logic [63:0] bits;
  word_t       hw [8];
  word_t       sched [16];
  vars_t       v, v_next;
  logic [6:0]  cnt;       // load byte index / round index
  logic        finishing, last_block;
  logic [2:0]  out_idx;
  logic        wr_en;
  logic [5:0]  wr_addr;
  logic [7:0]  wr_data;
  word_t       w_cur, w_calc, a15, a2;
  logic [31:0] shreg;

  assign s_tready = (state == StIdle);
  wire acc = s_tvalid && s_tready;
  wire func = s_tuser;

  always_comb begin
    wr_en = 1'b0; wr_addr = fill; wr_data = s_tdata;
    if (acc && func == FuncAbsorb) wr_en = 1'b1;
    else if (acc) begin wr_en = 1'b1; wr_data = PadByte; end
    else if (state == StPad) begin
      wr_en = 1'b1;
      if (!last_block && fill >= 6'(LenPos))
        wr_data = bits[8*(7 - (fill - 6'(LenPos))) +: 8];
      else wr_data = 8'h00;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) buf_mem[wr_addr] <= wr_data;
    rd_byte <= buf_mem[rd_addr];
  end

  assign rd_addr = cnt[5:0];
  assign a15 = sched[cnt[3:0] + 4'd1];
  assign a2 = sched[cnt[3:0] + 4'd14];
  assign w_calc = sched[cnt[3:0]] + (rotr(a15, 7) ^ rotr(a15, 18) ^ (a15 >> 3)) +
                  sched[cnt[3:0] + 4'd9] + (rotr(a2, 17) ^ rotr(a2, 19) ^ (a2 >> 10));
  assign w_cur = (cnt < 7'd16) ? sched[cnt[3:0]] : w_calc;

  sha_round u_round (.v(v), .k(RoundK[cnt[5:0]]), .w(w_cur), .v_next(v_next));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= StIdle; fill <= '0; byte_count <= '0; cnt <= '0;
      finishing <= 1'b0; last_block <= 1'b0; out_idx <= '0;
      for (int i = 0; i < 8; i++) hw[i] <= InitH[i];
    end else begin
      unique case (state)
        StIdle: if (acc) begin
          cnt <= '0;
          if (func == FuncAbsorb) begin
            if (byte_count != '1) byte_count <= byte_count + 64'd1;
            fill <= fill + 6'd1;
            if (fill == 6'd63) state <= StLoad;
          end else begin
            bits <= byte_count << 3;
            finishing <= 1'b1;
            fill <= fill + 6'd1;
            last_block <= (fill + 6'd1 > 6'(LenPos)) || (fill == 6'd63);
            // pad byte landed in last slot: block is full, compress now
            if (fill == 6'd63) state <= StLoad;
            else state <= StPad;
          end
        end
        StPad: begin
          fill <= fill + 6'd1;
          if (fill == 6'd63) begin state <= StLoad; cnt <= '0; end
        end
        StLoad: begin
          // rd_byte is byte cnt-1; pack big-endian into schedule
          if (cnt != 7'd0) begin
            shreg <= {shreg[23:0], rd_byte};
            if (cnt[1:0] == 2'd0) sched[4'(cnt[5:2] - 4'd1)] <= {shreg[23:0], rd_byte};
          end
          if (cnt == 7'd64) begin
            state <= StRound; cnt <= '0;
            v <= '{hw[0], hw[1], hw[2], hw[3], hw[4], hw[5], hw[6], hw[7]};
          end else cnt <= cnt + 7'd1;
        end
        StRound: begin
          v <= v_next;
          if (cnt >= 7'd16) sched[cnt[3:0]] <= w_calc;
          if (cnt == 7'd63) state <= StFold;
          else cnt <= cnt + 7'd1;
        end
        StFold: begin
          hw[0] <= hw[0] + v.a; hw[1] <= hw[1] + v.b; hw[2] <= hw[2] + v.c;
          hw[3] <= hw[3] + v.d; hw[4] <= hw[4] + v.e; hw[5] <= hw[5] + v.f;
          hw[6] <= hw[6] + v.g; hw[7] <= hw[7] + v.h;
          cnt <= '0; fill <= '0;
          if (!finishing) state <= StIdle;
          else if (last_block) begin last_block <= 1'b0; state <= StPad; end
          else begin state <= StOut; out_idx <= '0; end
        end
        StOut: if (m_tready) begin
          out_idx <= out_idx + 3'd1;
          if (out_idx == 3'd7) begin
            state <= StIdle; finishing <= 1'b0; byte_count <= '0; fill <= '0;
            for (int i = 0; i < 8; i++) hw[i] <= InitH[i];
          end
        end
        default: state <= StIdle;
      endcase
    end
  end

  assign m_tvalid = (state == StOut);
  assign m_tdata = {5'd0, out_idx, hw[out_idx]};
  assign m_tlast = (out_idx == 3'd7);

  `SHA_ASSERT_IMP(a_out_only_finish, m_tvalid, finishing, "output outside finish")
  `SHA_ASSERT_IMP(a_no_accept_busy, s_tready, !m_tvalid, "accept while emitting")
  `SHA_ASSERT_NEXT(a_last_idle, m_tvalid && m_tready && m_tlast, state == StIdle,
    "no return to idle after digest")
endmodule

// ===== test/tb_sha256_stream_hasher.sv =====
`timescale 1ns / 1ps

import sha_pkg::*;

class digest_scoreboard;
  typedef struct {
    word_t    word;
    bit [2:0] idx;
    bit       last;
  } digest_beat_t;

  digest_beat_t pending[$];
  int           errors;
  word_t        h[8];
  bit [7:0]     blk[64];
  int unsigned  fill;
  bit [63:0]    nbytes;

  function new();
    errors = 0;
    clear();
  endfunction

  function void clear();
    for (int i = 0; i < 8; i++) h[i] = InitH[i];
    fill   = 0;
    nbytes = '0;
  endfunction

  function word_t ror(word_t x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function void compress();
    word_t w[16];
    word_t a, b, c, d, e, f, g, hh, t1, t2, wr, x15, x2;
    for (int i = 0; i < 16; i++)
      w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
    {a, b, c, d, e, f, g, hh} = {h[0], h[1], h[2], h[3], h[4], h[5], h[6], h[7]};
    for (int r = 0; r < 64; r++) begin
      if (r < 16) begin
        wr = w[r];
      end else begin
        x15 = w[(r - 15) & 15];
        x2  = w[(r - 2) & 15];
        wr  = w[r & 15] + (ror(x15, 7) ^ ror(x15, 18) ^ (x15 >> 3)) + w[(r - 7) & 15]
            + (ror(x2, 17) ^ ror(x2, 19) ^ (x2 >> 10));
        w[r & 15] = wr;
      end
      t1 = hh + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25)) + ((e & f) ^ (~e & g)) + RoundK[r] + wr;
      t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      hh = g; g = f; f = e; e = d + t1;
      d = c; c = b; b = a; a = t1 + t2;
    end
    h[0] += a; h[1] += b; h[2] += c; h[3] += d;
    h[4] += e; h[5] += f; h[6] += g; h[7] += hh;
  endfunction

  // called once per accepted input byte
  function void note_item(bit func, bit [7:0] data);
    bit [63:0]    bitlen;
    digest_beat_t beat;
    if (func == FuncAbsorb) begin
      blk[fill] = data;
      fill++;
      if (nbytes != '1) nbytes++;
      if (fill == 64) begin
        compress();
        fill = 0;
      end
      return;
    end
    bitlen = nbytes << 3;
    blk[fill] = PadByte;
    fill++;
    if (fill > LenPos) begin
      for (int i = fill; i < 64; i++) blk[i] = 8'h00;
      compress();
      fill = 0;
    end
    for (int i = fill; i < LenPos; i++) blk[i] = 8'h00;
    for (int i = 0; i < 8; i++) blk[LenPos + i] = bitlen[(7 - i) * 8 +: 8];
    compress();
    for (int i = 0; i < 8; i++) begin
      beat.word = h[i];
      beat.idx  = i[2:0];
      beat.last = (i == 7);
      pending.push_back(beat);
    end
    clear();
  endfunction

  task report(string what);
    $display("mismatch at %0t: %s", $time, what);
    errors++;
  endtask

  task check_word(logic [39:0] tdata, logic tlast);
    digest_beat_t exp_beat;
    if (pending.size() == 0) begin
      report($sformatf("unexpected digest word %h", tdata));
      return;
    end
    exp_beat = pending.pop_front();
    if (tdata[31:0] !== exp_beat.word)
      report($sformatf("word %0d: got %h want %h", exp_beat.idx, tdata[31:0], exp_beat.word));
    if (tdata[34:32] !== exp_beat.idx)
      report($sformatf("index: got %0d want %0d", tdata[34:32], exp_beat.idx));
    if (tdata[39:35] !== 5'd0)
      report($sformatf("pad bits not zero: %h", tdata[39:35]));
    if (tlast !== exp_beat.last)
      report($sformatf("tlast on word %0d: got %b", exp_beat.idx, tlast));
  endtask
endclass

module tb_sha256_stream_hasher;
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic        m_tlast;

  digest_scoreboard sb = new();
  int unsigned      cycles = 0;
  int unsigned      hold_cycles = 0;
  bit               fast_phase = 0;

  sha256_stream_hasher DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (fast_phase || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // receiver: random stalls, or a long hold-off when requested
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= (pick_gap() == 0);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_word(m_tdata, m_tlast);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 600000) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task send(bit func, bit [7:0] data);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= data;
    s_tuser  <= func;
    do @(posedge clk); while (!s_tready);
    sb.note_item(func, data);
  endtask

  task send_message(int len, int fill_kind);
    bit [7:0] b;
    for (int i = 0; i < len; i++) begin
      case (fill_kind)
        0: b = 8'h00;
        1: b = 8'hff;
        default: b = $urandom_range(0, 255);
      endcase
      send(FuncAbsorb, b);
    end
    send(FuncFinish, $urandom_range(0, 255));
  endtask

  task drain();
    s_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  initial begin
    int items;
    int len;
    int r;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty message, single extreme bytes, then a short random message
    send_message(0, 2);
    send_message(1, 0);
    send_message(1, 1);
    send_message(3, 2);
    items = 9;

    // long receiver hold-off while the sender keeps streaming
    hold_cycles <= 400;
    fast_phase = 1;
    send_message(55, 2);
    send_message(2, 2);
    fast_phase = 0;
    items += 59;

    // sender waits for every digest before moving on
    drain();

    while (items < 370) begin
      r = $urandom_range(0, 9);
      if (r < 7) len = $urandom_range(0, 12);
      else case ($urandom_range(0, 6))
        0: len = 55;
        1: len = 56;
        2: len = 63;
        3: len = 64;
        4: len = 65;
        5: len = 119;
        default: len = 120;
      endcase
      send_message(len, 2);
      items += len + 1;
      if ($urandom_range(0, 7) == 0) drain();
    end

    drain();
    repeat (200) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
